// ===== rtl/core/hct_pkg.sv =====
// hct_pkg: widths, register indexes, stage types and divider step functions
// for the homography transfer error pipeline.
// No dependencies; used by homography_transfer_error.
`default_nettype none

package hct_pkg;

  // field formats
  localparam int unsigned COORD_WIDTH = 24;  // signed Q.8 coordinates
  localparam int unsigned COEF_WIDTH  = 32;  // signed Q.16 coefficients
  localparam int unsigned ERR_W       = 48;  // unsigned Q.8 squared error
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned HALF_W      = 32;  // coefficient slot in a register

  // fixed point shifts
  localparam int unsigned TERM_SHIFT = 8;    // Q.16 offset into Q.24 term
  localparam int unsigned FRAC_BITS  = 8;    // Q.24 / Q.24 -> Q.8 quotient

  // derived datapath widths
  localparam int unsigned PROD_W = COEF_WIDTH + COORD_WIDTH;   // coef * coord
  localparam int unsigned TERM_W = PROD_W + 2;                 // exact Q.24 term
  localparam int unsigned QUO_W  = COORD_WIDTH + 1;            // quotient bits
  localparam int unsigned TOP_W  = TERM_W + FRAC_BITS - QUO_W; // initial remainder
  localparam int unsigned DIFF_W = COORD_WIDTH + 1;            // dst - quotient
  localparam int unsigned SQ_W   = 2 * DIFF_W;
  localparam int unsigned SUM_W  = SQ_W + 1;
  localparam int unsigned WIDE_W = SUM_W + ERR_W;

  localparam logic [ERR_W-1:0]       ERR_MAX   = '1;
  localparam logic [COORD_WIDTH-1:0] LIM_NEG   = COORD_WIDTH'(1) << (COORD_WIDTH - 1);
  localparam logic [COORD_WIDTH-1:0] LIM_POS   = LIM_NEG - COORD_WIDTH'(1);
  localparam logic [COEF_WIDTH-1:0]  H22_RESET = COEF_WIDTH'(32'd65536);

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ROW0_A      = 3'd0,
    CFG_ROW0B_ROW1A = 3'd1,
    CFG_ROW1_B      = 3'd2,
    CFG_ROW2_A      = 3'd3,
    CFG_ROW2_B      = 3'd4
  } cfg_index_t;

  // one lane of the restoring divider: partial remainder and the shift
  // register that feeds dividend bits in and collects quotient bits
  typedef struct packed {
    logic [TERM_W-1:0] part;
    logic [QUO_W-1:0]  bits;
  } div_lane_t;

  typedef struct packed {
    logic      ovf;
    div_lane_t lane;
  } div_start_t;

  // divider pipeline stage payload
  typedef struct packed {
    div_lane_t                lane_x;
    div_lane_t                lane_y;
    logic [TERM_W-1:0]        den;
    logic                     neg_x;
    logic                     neg_y;
    logic                     ovf_x;
    logic                     ovf_y;
    logic                     deg;
    logic signed [COORD_WIDTH-1:0] dst_x;
    logic signed [COORD_WIDTH-1:0] dst_y;
  } div_stage_t;

  // magnitude of a signed term
  function automatic logic [TERM_W-1:0] term_mag(logic signed [TERM_W-1:0] t);
    logic [TERM_W-1:0] u;
    u = t;
    return t[TERM_W-1] ? (~u + TERM_W'(1)) : u;
  endfunction

  // numerator scaled to Q.8 result; quotient beyond QUO_W bits flags overflow
  function automatic div_start_t div_init(logic [TERM_W-1:0] num,
                                          logic [TERM_W-1:0] den);
    logic [TERM_W+FRAC_BITS-1:0] nx;
    logic [TERM_W-1:0]           top;
    div_start_t                  r;
    nx          = {num, FRAC_BITS'(0)};
    top         = TERM_W'(nx[TERM_W+FRAC_BITS-1:QUO_W]);
    r.ovf       = (top >= den);
    r.lane.part = r.ovf ? '0 : top;
    r.lane.bits = nx[QUO_W-1:0];
    return r;
  endfunction

  // one restoring step: shift in the next dividend bit, subtract if it fits
  function automatic div_lane_t div_step(div_lane_t in, logic [TERM_W-1:0] den);
    logic [TERM_W:0] pp;
    logic            ge;
    logic [TERM_W:0] diff;
    div_lane_t       r;
    pp     = {in.part, in.bits[QUO_W-1]};
    ge     = (pp >= {1'b0, den});
    diff   = pp - {1'b0, den};
    r.part = ge ? diff[TERM_W-1:0] : pp[TERM_W-1:0];
    r.bits = {in.bits[QUO_W-2:0], ge};
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/homography_transfer_error.sv =====
// Homography transfer error: one correspondence per cycle while the output
// register is not stalled. 34 register stages: 3 front stages, a divider
// entry stage, 25 divider stages one quotient bit each, 5 back stages.
// The whole pipeline advances unless the output register holds an untaken
// result. rst clears stage valid bits and loads the coefficient reset values.
// Depends on hct_pkg.
`default_nettype none

module homography_transfer_error (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  // input channel
  input  wire logic                                      in_valid,
  output logic                                           in_stall,
  input  wire logic signed [hct_pkg::COORD_WIDTH-1:0]    src_x,
  input  wire logic signed [hct_pkg::COORD_WIDTH-1:0]    src_y,
  input  wire logic signed [hct_pkg::COORD_WIDTH-1:0]    dst_x,
  input  wire logic signed [hct_pkg::COORD_WIDTH-1:0]    dst_y,
  // output channel
  output logic                                           out_valid,
  input  wire logic                                      out_stall,
  output logic [hct_pkg::ERR_W-1:0]                      sq_error,
  output logic                                           saturated,
  output logic                                           degenerate,
  // configuration write channel
  input  wire logic                                      cfg_valid,
  output logic                                           cfg_ready,
  input  wire logic [hct_pkg::CFG_INDEX_W-1:0]           cfg_index,
  input  wire logic [hct_pkg::CFG_DATA_W-1:0]            cfg_data
);

  localparam int unsigned CW = hct_pkg::COEF_WIDTH;
  localparam int unsigned HW = hct_pkg::HALF_W;
  localparam int unsigned QW = hct_pkg::QUO_W;

  // coefficient registers
  logic signed [CW-1:0] h00, h01, h02, h10, h11, h12, h20, h21, h22;

  // pipeline advance
  logic en;

  // stage 1: products
  logic                                        s1_valid;
  logic signed [hct_pkg::PROD_W-1:0]           s1_p0x, s1_p0y, s1_p1x, s1_p1y;
  logic signed [hct_pkg::PROD_W-1:0]           s1_p2x, s1_p2y;
  logic signed [hct_pkg::COORD_WIDTH-1:0]      s1_dst_x, s1_dst_y;

  // stage 2: projective terms
  logic                                        s2_valid;
  logic signed [hct_pkg::TERM_W-1:0]           s2_t1, s2_t2, s2_t3;
  logic signed [hct_pkg::COORD_WIDTH-1:0]      s2_dst_x, s2_dst_y;

  // stage 3: magnitudes and signs
  logic                                        s3_valid;
  logic [hct_pkg::TERM_W-1:0]                  s3_num_x, s3_num_y, s3_den;
  logic                                        s3_neg_x, s3_neg_y, s3_deg;
  logic signed [hct_pkg::COORD_WIDTH-1:0]      s3_dst_x, s3_dst_y;

  // divider stages
  logic                                        div_valid [0:QW];
  hct_pkg::div_stage_t                         div_q     [0:QW];
  hct_pkg::div_start_t                         start_x, start_y;

  // clip stage
  logic                                        clip_valid;
  logic [hct_pkg::COORD_WIDTH-1:0]             clip_qx, clip_qy;
  logic                                        clip_neg_x, clip_neg_y, clip_sat, clip_deg;
  logic signed [hct_pkg::COORD_WIDTH-1:0]      clip_dst_x, clip_dst_y;
  logic [hct_pkg::COORD_WIDTH-1:0]             lim_x, lim_y;
  logic                                        over_x, over_y;

  // difference stage
  logic                                        dif_valid;
  logic signed [hct_pkg::DIFF_W-1:0]           dif_x, dif_y;
  logic                                        dif_sat, dif_deg;
  logic signed [hct_pkg::DIFF_W-1:0]           dst_ext_x, dst_ext_y, q_ext_x, q_ext_y;

  // magnitude stage
  logic                                        mag_valid;
  logic [hct_pkg::DIFF_W-1:0]                  mag_x, mag_y;
  logic                                        mag_sat, mag_deg;

  // square stage
  logic                                        sq_valid;
  logic [hct_pkg::SQ_W-1:0]                    sq_x, sq_y;
  logic                                        sq_sat, sq_deg;

  // final sum and clamp
  logic [hct_pkg::SUM_W-1:0]                   sum;
  logic [hct_pkg::WIDE_W-1:0]                  wide;
  logic                                        err_over;

  // whole pipeline moves unless the output holds an untaken result
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      h00 <= '0; h01 <= '0; h02 <= '0;
      h10 <= '0; h11 <= '0; h12 <= '0;
      h20 <= '0; h21 <= '0; h22 <= hct_pkg::H22_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hct_pkg::CFG_ROW0_A: begin
          h00 <= cfg_data[HW+CW-1:HW];
          h01 <= cfg_data[CW-1:0];
        end
        hct_pkg::CFG_ROW0B_ROW1A: begin
          h02 <= cfg_data[HW+CW-1:HW];
          h10 <= cfg_data[CW-1:0];
        end
        hct_pkg::CFG_ROW1_B: begin
          h11 <= cfg_data[HW+CW-1:HW];
          h12 <= cfg_data[CW-1:0];
        end
        hct_pkg::CFG_ROW2_A: begin
          h20 <= cfg_data[HW+CW-1:HW];
          h21 <= cfg_data[CW-1:0];
        end
        hct_pkg::CFG_ROW2_B: begin
          h22 <= cfg_data[CW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // valid bits of the front and back stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      clip_valid <= 1'b0;
      dif_valid  <= 1'b0;
      mag_valid  <= 1'b0;
      sq_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else if (en) begin
      s1_valid   <= in_valid;
      s2_valid   <= s1_valid;
      s3_valid   <= s2_valid;
      clip_valid <= div_valid[QW];
      dif_valid  <= clip_valid;
      mag_valid  <= dif_valid;
      sq_valid   <= mag_valid;
      out_valid  <= sq_valid;
    end
  end

  // stage 1: six coefficient by coordinate products
  always_ff @(posedge clk) begin
    if (en) begin
      s1_p0x   <= h00 * src_x;
      s1_p0y   <= h01 * src_y;
      s1_p1x   <= h10 * src_x;
      s1_p1y   <= h11 * src_y;
      s1_p2x   <= h20 * src_x;
      s1_p2y   <= h21 * src_y;
      s1_dst_x <= dst_x;
      s1_dst_y <= dst_y;
    end
  end

  // stage 2: Q.24 terms, offset coefficient promoted from Q.16
  always_ff @(posedge clk) begin
    if (en) begin
      s2_t1 <= hct_pkg::TERM_W'(s1_p0x) + hct_pkg::TERM_W'(s1_p0y)
             + (hct_pkg::TERM_W'(h02) <<< hct_pkg::TERM_SHIFT);
      s2_t2 <= hct_pkg::TERM_W'(s1_p1x) + hct_pkg::TERM_W'(s1_p1y)
             + (hct_pkg::TERM_W'(h12) <<< hct_pkg::TERM_SHIFT);
      s2_t3 <= hct_pkg::TERM_W'(s1_p2x) + hct_pkg::TERM_W'(s1_p2y)
             + (hct_pkg::TERM_W'(h22) <<< hct_pkg::TERM_SHIFT);
      s2_dst_x <= s1_dst_x;
      s2_dst_y <= s1_dst_y;
    end
  end

  // stage 3: unsigned operands and quotient signs
  always_ff @(posedge clk) begin
    if (en) begin
      s3_num_x <= hct_pkg::term_mag(s2_t1);
      s3_num_y <= hct_pkg::term_mag(s2_t2);
      s3_den   <= hct_pkg::term_mag(s2_t3);
      s3_neg_x <= s2_t1[hct_pkg::TERM_W-1] ^ s2_t3[hct_pkg::TERM_W-1];
      s3_neg_y <= s2_t2[hct_pkg::TERM_W-1] ^ s2_t3[hct_pkg::TERM_W-1];
      s3_deg   <= (s2_t3 == '0);
      s3_dst_x <= s2_dst_x;
      s3_dst_y <= s2_dst_y;
    end
  end

  // divider entry: overflow check and initial remainder
  always_comb begin
    start_x = hct_pkg::div_init(s3_num_x, s3_den);
    start_y = hct_pkg::div_init(s3_num_y, s3_den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_valid[0] <= 1'b0;
    end else if (en) begin
      div_valid[0] <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_q[0].lane_x <= start_x.lane;
      div_q[0].lane_y <= start_y.lane;
      div_q[0].ovf_x  <= start_x.ovf;
      div_q[0].ovf_y  <= start_y.ovf;
      div_q[0].den    <= s3_den;
      div_q[0].neg_x  <= s3_neg_x;
      div_q[0].neg_y  <= s3_neg_y;
      div_q[0].deg    <= s3_deg;
      div_q[0].dst_x  <= s3_dst_x;
      div_q[0].dst_y  <= s3_dst_y;
    end
  end

  // divider steps: one quotient bit per stage for both lanes
  for (genvar k = 1; k <= QW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        div_valid[k] <= 1'b0;
      end else if (en) begin
        div_valid[k] <= div_valid[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_q[k].lane_x <= hct_pkg::div_step(div_q[k-1].lane_x, div_q[k-1].den);
        div_q[k].lane_y <= hct_pkg::div_step(div_q[k-1].lane_y, div_q[k-1].den);
        div_q[k].den    <= div_q[k-1].den;
        div_q[k].neg_x  <= div_q[k-1].neg_x;
        div_q[k].neg_y  <= div_q[k-1].neg_y;
        div_q[k].ovf_x  <= div_q[k-1].ovf_x;
        div_q[k].ovf_y  <= div_q[k-1].ovf_y;
        div_q[k].deg    <= div_q[k-1].deg;
        div_q[k].dst_x  <= div_q[k-1].dst_x;
        div_q[k].dst_y  <= div_q[k-1].dst_y;
      end
    end
  end

  // clip stage: quotient magnitude limited to the coordinate range
  always_comb begin
    lim_x  = div_q[QW].neg_x ? hct_pkg::LIM_NEG : hct_pkg::LIM_POS;
    lim_y  = div_q[QW].neg_y ? hct_pkg::LIM_NEG : hct_pkg::LIM_POS;
    over_x = div_q[QW].ovf_x || (div_q[QW].lane_x.bits > QW'(lim_x));
    over_y = div_q[QW].ovf_y || (div_q[QW].lane_y.bits > QW'(lim_y));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clip_qx    <= over_x ? lim_x : div_q[QW].lane_x.bits[hct_pkg::COORD_WIDTH-1:0];
      clip_qy    <= over_y ? lim_y : div_q[QW].lane_y.bits[hct_pkg::COORD_WIDTH-1:0];
      clip_sat   <= over_x || over_y;
      clip_neg_x <= div_q[QW].neg_x;
      clip_neg_y <= div_q[QW].neg_y;
      clip_deg   <= div_q[QW].deg;
      clip_dst_x <= div_q[QW].dst_x;
      clip_dst_y <= div_q[QW].dst_y;
    end
  end

  // difference stage: dst minus signed quotient as one add or subtract
  always_comb begin
    dst_ext_x = hct_pkg::DIFF_W'(clip_dst_x);
    dst_ext_y = hct_pkg::DIFF_W'(clip_dst_y);
    q_ext_x   = $signed({1'b0, clip_qx});
    q_ext_y   = $signed({1'b0, clip_qy});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dif_x   <= clip_neg_x ? (dst_ext_x + q_ext_x) : (dst_ext_x - q_ext_x);
      dif_y   <= clip_neg_y ? (dst_ext_y + q_ext_y) : (dst_ext_y - q_ext_y);
      dif_sat <= clip_sat;
      dif_deg <= clip_deg;
    end
  end

  // magnitude stage
  always_ff @(posedge clk) begin
    if (en) begin
      mag_x   <= dif_x[hct_pkg::DIFF_W-1] ? (~dif_x + hct_pkg::DIFF_W'(1)) : dif_x;
      mag_y   <= dif_y[hct_pkg::DIFF_W-1] ? (~dif_y + hct_pkg::DIFF_W'(1)) : dif_y;
      mag_sat <= dif_sat;
      mag_deg <= dif_deg;
    end
  end

  // square stage
  always_ff @(posedge clk) begin
    if (en) begin
      sq_x   <= hct_pkg::SQ_W'(mag_x) * hct_pkg::SQ_W'(mag_x);
      sq_y   <= hct_pkg::SQ_W'(mag_y) * hct_pkg::SQ_W'(mag_y);
      sq_sat <= mag_sat;
      sq_deg <= mag_deg;
    end
  end

  // sum of squares back to Q.8, clamped to the error range
  always_comb begin
    sum      = hct_pkg::SUM_W'(sq_x) + hct_pkg::SUM_W'(sq_y);
    wide     = hct_pkg::WIDE_W'(sum) >> hct_pkg::FRAC_BITS;
    err_over = |wide[hct_pkg::WIDE_W-1:hct_pkg::ERR_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sq_deg) begin
        sq_error <= hct_pkg::ERR_MAX;
        saturated <= 1'b0;
      end else begin
        sq_error  <= err_over ? hct_pkg::ERR_MAX : wide[hct_pkg::ERR_W-1:0];
        saturated <= sq_sat || err_over;
      end
      degenerate <= sq_deg;
    end
  end

  // a zero denominator always reports the full-scale error and no clipping
  a_degenerate_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> (sq_error == hct_pkg::ERR_MAX) && !saturated)
    else $error("degenerate result without full-scale error");

  // restoring divider keeps each remainder below the denominator
  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    div_valid[QW] && !div_q[QW].deg |->
      (div_q[QW].lane_x.part < div_q[QW].den) &&
      (div_q[QW].lane_y.part < div_q[QW].den))
    else $error("divider remainder not below denominator");

  // clipped quotient magnitude stays within the coordinate range
  a_clip_range: assert property (@(posedge clk) disable iff (rst)
    clip_valid |-> (clip_qx <= hct_pkg::LIM_NEG) && (clip_qy <= hct_pkg::LIM_NEG))
    else $error("clipped quotient out of range");

endmodule

`default_nettype wire
